// File: src/lcv_pkg.sv
// Shared types and constants for the linear copy layout validator.
// Holds the transfer payload structs, the status codes and the inter-stage structs.
// No dependencies.
`default_nettype none

package lcv_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISALIGNED  = 3'd1,
    ST_DEPTH_MISS  = 3'd2,
    ST_ROW_MISS    = 3'd3,
    ST_ROW_LONG    = 3'd4,
    ST_ROWS_EXCEED = 3'd5,
    ST_OVERFLOW    = 3'd6,
    ST_NO_FIT      = 3'd7
  } lcv_status_e;

  typedef struct packed {
    logic [31:0] copy_width;
    logic [31:0] copy_height;
    logic [31:0] copy_depth;
    logic [4:0]  block_width;
    logic [4:0]  block_height;
    logic [4:0]  block_bytes;
    logic [31:0] row_stride;
    logic        row_stride_given;
    logic [31:0] image_stride_rows;
    logic        image_stride_given;
    logic [63:0] data_offset;
    logic [63:0] data_size;
  } lcv_in_t;

  typedef struct packed {
    lcv_status_e status;
    logic [63:0] required_bytes;
  } lcv_out_t;

  // long division: 32 quotient bits, LCV_DIV_STEPS per stage
  localparam int unsigned LCV_DIV_STAGES = 4;
  localparam int unsigned LCV_DIV_STEPS  = 32 / LCV_DIV_STAGES;

  typedef struct packed {
    lcv_in_t     item;
    logic [31:0] wblk;
    logic [31:0] hblk;
    logic [4:0]  wrem;
    logic [4:0]  hrem;
  } lcv_div_t;

  typedef struct packed {
    lcv_status_e status;
    logic        cd_nz;
    logic        no_room;
    logic [63:0] per_image;
    logic [63:0] pp_lo;
    logic [63:0] pp_hi;
    logic [63:0] base;
    logic [63:0] avail;
  } lcv_ext_t;

endpackage

`default_nettype wire

// File: src/lcv_blk_div.sv
// Block division: copy width and height divided by the block size.
// Four-stage restoring long division, eight quotient bits per stage. Uses lcv_pkg.
`default_nettype none

module lcv_blk_div import lcv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire lcv_in_t  item_i,
  output logic          adv_o,
  output logic          valid_o,
  output lcv_div_t      data_o,
  input  wire logic     adv_i
);

  typedef struct packed {
    logic [31:0] word;
    logic [4:0]  rem;
  } dstep_t;

  function automatic dstep_t div_steps(dstep_t s, logic [4:0] d);
    logic [5:0] t;
    dstep_t     o;
    o = s;
    for (int k = 0; k < LCV_DIV_STEPS; k++) begin
      t = {o.rem, o.word[31]};
      o.word = {o.word[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        o.word[0] = 1'b1;
      end
      o.rem = t[4:0];
    end
    return o;
  endfunction

  logic [LCV_DIV_STAGES-1:0] valid_q;
  logic [LCV_DIV_STAGES-1:0] valid_d;
  logic [LCV_DIV_STAGES:0]   en;
  lcv_in_t                   item_q [LCV_DIV_STAGES];
  lcv_in_t                   item_d [LCV_DIV_STAGES];
  dstep_t                    w_q    [LCV_DIV_STAGES];
  dstep_t                    w_d    [LCV_DIV_STAGES];
  dstep_t                    h_q    [LCV_DIV_STAGES];
  dstep_t                    h_d    [LCV_DIV_STAGES];

  always_comb begin
    en[LCV_DIV_STAGES] = adv_i;
    for (int k = LCV_DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = valid_i;
    item_d[0]  = item_i;
    w_d[0]     = div_steps('{word: item_i.copy_width, rem: 5'd0}, item_i.block_width);
    h_d[0]     = div_steps('{word: item_i.copy_height, rem: 5'd0}, item_i.block_height);
    for (int k = 1; k < LCV_DIV_STAGES; k++) begin
      valid_d[k] = valid_q[k-1];
      item_d[k]  = item_q[k-1];
      w_d[k]     = div_steps(w_q[k-1], item_q[k-1].block_width);
      h_d[k]     = div_steps(h_q[k-1], item_q[k-1].block_height);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < LCV_DIV_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LCV_DIV_STAGES; k++) begin
      if (en[k]) begin
        item_q[k] <= item_d[k];
        w_q[k]    <= w_d[k];
        h_q[k]    <= h_d[k];
      end
    end
  end

  assign adv_o       = en[0];
  assign valid_o     = valid_q[LCV_DIV_STAGES-1];
  assign data_o.item = item_q[LCV_DIV_STAGES-1];
  assign data_o.wblk = w_q[LCV_DIV_STAGES-1].word;
  assign data_o.hblk = h_q[LCV_DIV_STAGES-1].word;
  assign data_o.wrem = w_q[LCV_DIV_STAGES-1].rem;
  assign data_o.hrem = h_q[LCV_DIV_STAGES-1].rem;

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LCV_DIV_STAGES-1] && !adv_i |=> valid_q[LCV_DIV_STAGES-1] &&
      $stable(w_q[LCV_DIV_STAGES-1]) && $stable(h_q[LCV_DIV_STAGES-1]))
    else $error("held division result changed");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && data_o.item.block_width != 5'd0 |-> data_o.wrem < data_o.item.block_width)
    else $error("width remainder not below block width");

endmodule

`default_nettype wire

// File: src/lcv_extent.sv
// Extent stages: row and image byte sizes, the ordered descriptor checks and
// the partial products of the depth multiply. Two register stages. Uses lcv_pkg.
`default_nettype none

module lcv_extent import lcv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire lcv_div_t data_i,
  output logic          adv_o,
  output logic          valid_o,
  output lcv_ext_t      data_o,
  input  wire logic     adv_i
);

  logic [1:0]  valid_q;
  logic [2:0]  en;

  // stage 1
  logic        misal_q, misal_d;
  lcv_in_t     item_q;
  logic [31:0] hblk_q;
  logic [36:0] last_row_q, last_row_d;
  logic [63:0] per_image_q, per_image_d;
  logic [63:0] t_row_q, t_row_d;
  logic [31:0] stride, rows;

  // stage 2
  lcv_ext_t    ext_q, ext_d;

  always_comb begin
    en[2] = adv_i;
    en[1] = !valid_q[1] || en[2];
    en[0] = !valid_q[0] || en[1];
  end

  always_comb begin
    stride      = data_i.item.row_stride_given ? data_i.item.row_stride : 32'd0;
    rows        = data_i.item.image_stride_given ? data_i.item.image_stride_rows : 32'd0;
    misal_d     = (data_i.item.block_width == 5'd0) || (data_i.item.block_height == 5'd0) ||
                  (data_i.wrem != 5'd0) || (data_i.hrem != 5'd0);
    last_row_d  = {5'd0, data_i.wblk} * {32'd0, data_i.item.block_bytes};
    per_image_d = {32'd0, stride} * {32'd0, rows};
    t_row_d     = {32'd0, stride} * {32'd0, data_i.hblk - 32'd1};
  end

  always_comb begin
    if (misal_q) begin
      ext_d.status = ST_MISALIGNED;
    end else if (item_q.copy_depth > 32'd1 &&
                 (!item_q.row_stride_given || !item_q.image_stride_given)) begin
      ext_d.status = ST_DEPTH_MISS;
    end else if (hblk_q > 32'd1 && !item_q.row_stride_given) begin
      ext_d.status = ST_ROW_MISS;
    end else if (item_q.row_stride_given && last_row_q > {5'd0, item_q.row_stride}) begin
      ext_d.status = ST_ROW_LONG;
    end else if (item_q.image_stride_given && hblk_q > item_q.image_stride_rows) begin
      ext_d.status = ST_ROWS_EXCEED;
    end else begin
      ext_d.status = ST_OK;
    end
    ext_d.cd_nz     = item_q.copy_depth != 32'd0;
    ext_d.no_room   = item_q.data_offset > item_q.data_size;
    ext_d.per_image = per_image_q;
    ext_d.pp_lo     = {32'd0, per_image_q[31:0]} * {32'd0, item_q.copy_depth};
    ext_d.pp_hi     = {32'd0, per_image_q[63:32]} * {32'd0, item_q.copy_depth};
    ext_d.base      = (hblk_q != 32'd0) ? t_row_q + {27'd0, last_row_q} : 64'd0;
    ext_d.avail     = item_q.data_size - item_q.data_offset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= valid_i;
      end
      if (en[1]) begin
        valid_q[1] <= valid_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      misal_q     <= misal_d;
      item_q      <= data_i.item;
      hblk_q      <= data_i.hblk;
      last_row_q  <= last_row_d;
      per_image_q <= per_image_d;
      t_row_q     <= t_row_d;
    end
    if (en[1]) begin
      ext_q <= ext_d;
    end
  end

  assign adv_o   = en[0];
  assign valid_o = valid_q[1];
  assign data_o  = ext_q;

endmodule

`default_nettype wire

// File: src/lcv_size.sv
// Size stages: full depth product, overflow test, required byte count and the
// fit check against the buffer. Three register stages, the last drives the output. Uses lcv_pkg.
`default_nettype none

module lcv_size import lcv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire lcv_ext_t data_i,
  output logic          adv_o,
  output logic          valid_o,
  output lcv_out_t      data_o,
  input  wire logic     adv_i
);

  logic [2:0]  valid_q;
  logic [3:0]  en;

  lcv_ext_t    ext_q;
  logic [95:0] prod_q, prod_d;

  lcv_status_e status_q;
  logic        no_room_q;
  logic [63:0] avail_q;
  logic        over_q, over_d;
  logic [63:0] req_q, req_d;

  lcv_out_t    out_q, out_d;

  always_comb begin
    en[3] = adv_i;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign prod_d = {32'd0, data_i.pp_lo} + {data_i.pp_hi, 32'd0};

  always_comb begin
    over_d = ext_q.cd_nz && (prod_q[95:64] != 32'd0);
    req_d  = ext_q.cd_nz ? prod_q[63:0] - ext_q.per_image + ext_q.base : 64'd0;
  end

  always_comb begin
    if (status_q != ST_OK) begin
      out_d.status         = status_q;
      out_d.required_bytes = 64'd0;
    end else if (over_q) begin
      out_d.status         = ST_OVERFLOW;
      out_d.required_bytes = 64'd0;
    end else if (no_room_q || req_q > avail_q) begin
      out_d.status         = ST_NO_FIT;
      out_d.required_bytes = req_q;
    end else begin
      out_d.status         = ST_OK;
      out_d.required_bytes = req_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= valid_i;
      end
      if (en[1]) begin
        valid_q[1] <= valid_q[0];
      end
      if (en[2]) begin
        valid_q[2] <= valid_q[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ext_q  <= data_i;
      prod_q <= prod_d;
    end
    if (en[1]) begin
      status_q  <= ext_q.status;
      no_room_q <= ext_q.no_room;
      avail_q   <= ext_q.avail;
      over_q    <= over_d;
      req_q     <= req_d;
    end
    if (en[2]) begin
      out_q <= out_d;
    end
  end

  assign adv_o   = en[0];
  assign valid_o = valid_q[2];
  assign data_o  = out_q;

  a_early_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] && (out_q.status == ST_MISALIGNED || out_q.status == ST_DEPTH_MISS ||
      out_q.status == ST_ROW_MISS || out_q.status == ST_ROW_LONG ||
      out_q.status == ST_ROWS_EXCEED || out_q.status == ST_OVERFLOW)
      |-> out_q.required_bytes == 64'd0)
    else $error("failed check carries a byte count");

  a_move_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] && en[2] |=> valid_q[2])
    else $error("item lost entering output stage");

endmodule

`default_nettype wire

// File: src/linear_copy_layout_validator.sv
// Top level of the linear copy layout validator.
// Chains lcv_blk_div, lcv_extent and lcv_size. Uses lcv_pkg.
//
// Takes one copy descriptor per cycle while in_stall_o is low and returns one
// status and byte count per descriptor, in order. The pipeline is made up of
// the 32-bit long division of the extent by the block size (four stages of
// eight quotient bits), two stages of stride multiplies and checks, and three
// stages for the 96-bit depth product, the byte count and the fit compare.
// Every stage holds its own valid bit, so empty stages fill while the output
// waits.
`default_nettype none

module linear_copy_layout_validator import lcv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire lcv_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lcv_out_t      out_data_o
);

  logic     div_adv, ext_adv, size_adv;
  logic     div_valid, ext_valid;
  lcv_div_t div_data;
  lcv_ext_t ext_data;

  lcv_blk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .adv_o   (div_adv),
    .valid_o (div_valid),
    .data_o  (div_data),
    .adv_i   (ext_adv)
  );

  lcv_extent u_ext (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .data_i  (div_data),
    .adv_o   (ext_adv),
    .valid_o (ext_valid),
    .data_o  (ext_data),
    .adv_i   (size_adv)
  );

  lcv_size u_size (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ext_valid),
    .data_i  (ext_data),
    .adv_o   (size_adv),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .adv_i   (!out_stall_i)
  );

  assign in_stall_o = !div_adv;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for linear_copy_layout_validator: directed descriptors and random ones,
// each checked against an in-bench layout predictor, under random idling and stalls.
// Depends on lcv_pkg and the linear_copy_layout_validator RTL.
`default_nettype none

module tb_top;
  import lcv_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  lcv_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  lcv_out_t out_data_o;

  linear_copy_layout_validator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  lcv_out_t layout_q[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_reqs;
  int       hold_len;
  int       hold_seen;
  int       hold_left;
  int       descriptors_sent;
  int       results_checked;
  int       mismatches;
  int       status_seen[8];

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  // bit-exact predictor of status and required byte count
  function automatic lcv_out_t predict_layout(input lcv_in_t d);
    lcv_out_t    r;
    logic [63:0] wblk;
    logic [63:0] hblk;
    logic [63:0] last_row;
    logic [63:0] stride;
    logic [63:0] rows;
    logic [63:0] per_image;
    logic [63:0] req;
    logic        misaligned;
    req = '0;
    misaligned = 1'b1;
    if (d.block_width != 0 && d.block_height != 0) begin
      misaligned = (d.copy_width % d.block_width) != 0 ||
                   (d.copy_height % d.block_height) != 0;
    end
    if (misaligned) begin
      r.status = ST_MISALIGNED;
    end else begin
      wblk = 64'(d.copy_width / d.block_width);
      hblk = 64'(d.copy_height / d.block_height);
      last_row = wblk * 64'(d.block_bytes);
      stride = d.row_stride_given ? 64'(d.row_stride) : 64'd0;
      rows = d.image_stride_given ? 64'(d.image_stride_rows) : 64'd0;
      if (d.copy_depth > 1 && (!d.row_stride_given || !d.image_stride_given)) begin
        r.status = ST_DEPTH_MISS;
      end else if (hblk > 1 && !d.row_stride_given) begin
        r.status = ST_ROW_MISS;
      end else if (d.row_stride_given && last_row > 64'(d.row_stride)) begin
        r.status = ST_ROW_LONG;
      end else if (d.image_stride_given && hblk > 64'(d.image_stride_rows)) begin
        r.status = ST_ROWS_EXCEED;
      end else begin
        per_image = stride * rows;
        if (d.copy_depth != 0 && per_image > 64'hFFFF_FFFF_FFFF_FFFF / 64'(d.copy_depth)) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (d.copy_depth != 0) begin
            req = per_image * (64'(d.copy_depth) - 64'd1);
            if (hblk > 0) begin
              req = req + stride * (hblk - 64'd1) + last_row;
            end
          end
          if (d.data_offset > d.data_size || req > d.data_size - d.data_offset) begin
            r.status = ST_NO_FIT;
          end else begin
            r.status = ST_OK;
          end
        end
      end
    end
    r.required_bytes = req;
    return r;
  endfunction

  function automatic lcv_in_t mk(input logic [31:0] cw, input logic [31:0] ch,
                                 input logic [31:0] cd, input logic [4:0] bw,
                                 input logic [4:0] bh, input logic [4:0] bb,
                                 input logic [31:0] rs, input logic rsg,
                                 input logic [31:0] ir, input logic irg,
                                 input logic [63:0] off, input logic [63:0] size);
    lcv_in_t d;
    d.copy_width = cw;
    d.copy_height = ch;
    d.copy_depth = cd;
    d.block_width = bw;
    d.block_height = bh;
    d.block_bytes = bb;
    d.row_stride = rs;
    d.row_stride_given = rsg;
    d.image_stride_rows = ir;
    d.image_stride_given = irg;
    d.data_offset = off;
    d.data_size = size;
    return d;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      8: return $urandom_range(65, 5000);
      9: return $urandom;
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  function automatic lcv_in_t make_descriptor();
    lcv_in_t     d;
    lcv_out_t    r;
    logic [31:0] wblk;
    logic [31:0] hblk;
    logic [63:0] last_row;
    int          kind;
    kind = $urandom_range(99);
    if (kind < 12) begin
      return mk($urandom, $urandom, $urandom, 5'($urandom_range(31)),
                5'($urandom_range(31)), 5'($urandom_range(31)), $urandom,
                1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                rand64(), rand64());
    end
    d.block_width  = 5'(($urandom_range(9) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(1, 16));
    d.block_height = 5'(($urandom_range(9) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(1, 16));
    d.block_bytes  = 5'(($urandom_range(9) == 0) ? $urandom_range(31)
                                                  : $urandom_range(1, 16));
    wblk = pick_count();
    hblk = pick_count();
    d.copy_width = wblk * d.block_width;
    d.copy_height = hblk * d.block_height;
    if (kind < 18 && d.block_width > 1) begin
      d.copy_width = d.copy_width + $urandom_range(1, d.block_width - 1);
    end
    case ($urandom_range(9))
      0: d.copy_depth = 32'd0;
      1, 2, 3, 4: d.copy_depth = 32'd1;
      9: d.copy_depth = $urandom;
      default: d.copy_depth = $urandom_range(2, 8);
    endcase
    d.row_stride_given = ($urandom_range(9) != 0);
    d.image_stride_given = ($urandom_range(9) != 0);
    last_row = 64'(wblk) * 64'(d.block_bytes);
    if (last_row[63:32] == 0 && $urandom_range(7) != 0) begin
      d.row_stride = last_row[31:0] + $urandom_range(0, 64) - ($urandom_range(7) == 0);
    end else begin
      d.row_stride = $urandom;
    end
    d.image_stride_rows = hblk + $urandom_range(0, 3) - ($urandom_range(7) == 0);
    d.data_offset = ($urandom_range(1) == 0) ? 64'($urandom_range(0, 4096))
                                             : rand64() >> $urandom_range(1, 63);
    d.data_size = '1;
    r = predict_layout(mk(d.copy_width, d.copy_height, d.copy_depth, d.block_width,
                          d.block_height, d.block_bytes, d.row_stride, d.row_stride_given,
                          d.image_stride_rows, d.image_stride_given, 64'd0, '1));
    if ($urandom_range(9) == 0) begin
      d.data_size = rand64();
    end else begin
      d.data_size = d.data_offset + r.required_bytes + 64'($urandom_range(4)) - 64'd2;
    end
    return d;
  endfunction

  task automatic send_copy(input lcv_in_t d);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    layout_q.push_back(predict_layout(d));
    descriptors_sent++;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic check_result(input lcv_out_t got);
    lcv_out_t want;
    if (layout_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: status %0d bytes %0h", got.status, got.required_bytes);
      end
      return;
    end
    want = layout_q.pop_front();
    results_checked++;
    status_seen[want.status]++;
    if (got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("status mismatch: expected %0d, got %0d", want.status, got.status);
      end
    end
    if (got.required_bytes !== want.required_bytes) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("required_bytes mismatch: expected %0h, got %0h",
                 want.required_bytes, got.required_bytes);
      end
    end
  endtask

  // receiver: checks each transfer, then decides the stall for the next cycle
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      check_result(out_data_o);
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic test_status_codes();
    send_copy(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_copy(mk(4, 4, 1, 4, 0, 4, 16, 1, 1, 1, 0, '1));
    send_copy(mk(5, 4, 1, 4, 4, 16, 64, 1, 4, 1, 0, '1));
    send_copy(mk(8, 6, 1, 4, 4, 16, 64, 1, 4, 1, 0, '1));
    send_copy(mk(8, 8, 2, 1, 1, 4, 32, 1, 0, 0, 0, '1));
    send_copy(mk(8, 8, 3, 1, 1, 4, 0, 0, 8, 1, 0, '1));
    send_copy(mk(8, 8, 1, 1, 1, 4, 0, 0, 8, 1, 0, '1));
    send_copy(mk(8, 8, 1, 1, 1, 4, 31, 1, 8, 1, 0, '1));
    send_copy(mk(8, 8, 1, 1, 1, 4, 32, 1, 7, 1, 0, '1));
    send_copy(mk(8, 8, 3, 1, 1, 4, '1, 1, '1, 1, 0, '1));
    send_copy(mk(8, 8, 2, 1, 1, 4, 32, 1, 8, 1, 100, 99));
    send_copy(mk(8, 8, 2, 1, 1, 4, 32, 1, 8, 1, 0, 511));
    send_copy(mk(8, 8, 2, 1, 1, 4, 32, 1, 8, 1, 0, 512));
  endtask

  task automatic test_field_extremes();
    // zero depth: only the offset can fail
    send_copy(mk(16, 16, 0, 4, 4, 8, 64, 1, 4, 1, 10, 9));
    send_copy(mk(16, 16, 0, 4, 4, 8, 64, 1, 4, 1, '1, '1));
    send_copy(mk('1, '1, 1, 1, 1, 31, '1, 1, '1, 1, 0, '1));
    send_copy(mk('1, '1, 1, 1, 1, 1, '1, 1, '1, 1, 0, '1));
    send_copy(mk(1, 1, '1, 1, 1, 1, 1, 1, 1, 1, 0, '1));
    send_copy(mk(1, 1, '1, 1, 1, 1, '1, 1, '1, 1, 0, '1));
    send_copy(mk(93, 62, 1, 31, 31, 31, 93, 1, 2, 1, 0, '1));
    send_copy(mk(30, 31, 1, 31, 31, 31, 93, 1, 2, 1, 0, '1));
    send_copy(mk(16, 1, 1, 1, 1, 2, 0, 0, 0, 0, 0, 32));
    send_copy(mk(0, 8, 1, 1, 1, 4, 0, 1, 8, 1, 0, 0));
    send_copy(mk(4, 0, 1, 1, 1, 4, 0, 0, 0, 0, 0, 4));
    send_copy(mk(2, 3, 1, 1, 1, 16, '1, 1, 0, 0, 5, '1));
    send_copy(mk(1, 1, 1, 1, 1, 1, 0, 0, 0, 0, '1, '1));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_copy(make_descriptor());
  endtask

  // receiver holds off while descriptors keep coming, so the pipeline fills
  task automatic test_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 200;
    hold_reqs++;
    repeat (40) send_copy(make_descriptor());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (layout_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 80;
    hold_reqs = 0;
    hold_len = 0;
    hold_seen = 0;
    hold_left = 0;
    descriptors_sent = 0;
    results_checked = 0;
    mismatches = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_status_codes();
    test_field_extremes();
    test_random(240);
    send_idle_pct = 80;
    recv_idle_pct = 16;
    test_random(240);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(220);
    test_pressure();
    drain();

    $display("%0d copy descriptors sent, %0d results checked, %0d mismatches",
             descriptors_sent, results_checked, mismatches);
    $display(
      "status mix: ok %0d, misal %0d, depth %0d, row %0d, long %0d, rows %0d, ovf %0d, fit %0d",
      status_seen[ST_OK], status_seen[ST_MISALIGNED], status_seen[ST_DEPTH_MISS],
      status_seen[ST_ROW_MISS], status_seen[ST_ROW_LONG], status_seen[ST_ROWS_EXCEED],
      status_seen[ST_OVERFLOW], status_seen[ST_NO_FIT]);
    if (mismatches == 0 && layout_q.size() == 0) begin
      $display("[linear_copy_layout_validator] OK");
    end else begin
      $display("[linear_copy_layout_validator] ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd400_000 * 20);
    $display("timeout with %0d results outstanding", layout_q.size());
    $display("[linear_copy_layout_validator] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
